>>> sv/pci_location_string_parser_defines.svh
// ---------------------------------------------------------------------------
// pci location string parser assertion macros
// shared property forms for the parser checks
// ---------------------------------------------------------------------------
`ifndef PCI_LOCATION_STRING_PARSER_DEFINES_SVH
`define PCI_LOCATION_STRING_PARSER_DEFINES_SVH

// same-cycle implication
`define PCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pcl_pkg.sv
// ---------------------------------------------------------------------------
// pcl_pkg
// types and constants shared by the location string parser
// ---------------------------------------------------------------------------
`default_nettype none

package pcl_pkg;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_DEVICE = 2'd2;
    localparam logic [1:0] PH_FUNC   = 2'd3;

    localparam logic [7:0] CHAR_TERM  = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;

    localparam logic [2:0] MAX_WIDE_DIGITS = 3'd4;
    localparam logic [2:0] MAX_DEV_DIGITS  = 3'd2;
    localparam logic [2:0] MAX_FUNC_DIGITS = 3'd1;

    localparam logic [15:0] BUS_MAX  = 16'h00ff;
    localparam logic [15:0] DEV_MAX  = 16'h001f;
    localparam logic [3:0]  FUNC_MAX = 4'h7;

    typedef struct packed {
        logic       is_term;
        logic       is_hex;
        logic       is_colon;
        logic       is_dot;
        logic [3:0] digit;
    } t_char_info;

    typedef struct packed {
        logic        ok;
        logic [15:0] domain_num;
        logic [7:0]  bus_num;
        logic [4:0]  device_num;
        logic [2:0]  function_num;
    } t_result;

endpackage

`default_nettype wire

>>> sv/pcl_char_decode.sv
// ---------------------------------------------------------------------------
// pcl_char_decode
// classifies one string byte: terminator, separator or hex digit value
// ---------------------------------------------------------------------------
`default_nettype none

module pcl_char_decode
    import pcl_pkg::*;
(
    input  wire logic [7:0] i_char_byte,
    output t_char_info      o_info
);

    logic       w_num;
    logic       w_upper;
    logic       w_lower;
    logic [7:0] w_val;

    always_comb begin
        w_num   = (i_char_byte >= 8'h30) && (i_char_byte <= 8'h39);
        w_upper = (i_char_byte >= 8'h41) && (i_char_byte <= 8'h46);
        w_lower = (i_char_byte >= 8'h61) && (i_char_byte <= 8'h66);
        priority if (w_num) begin
            w_val = i_char_byte - 8'h30;
        end else if (w_upper) begin
            w_val = i_char_byte - 8'h37;
        end else if (w_lower) begin
            w_val = i_char_byte - 8'h57;
        end else begin
            w_val = 8'h00;
        end
        o_info.is_term  = (i_char_byte == CHAR_TERM);
        o_info.is_hex   = w_num || w_upper || w_lower;
        o_info.is_colon = (i_char_byte == CHAR_COLON);
        o_info.is_dot   = (i_char_byte == CHAR_DOT);
        o_info.digit    = w_val[3:0];
    end

endmodule

`default_nettype wire

>>> sv/pcl_parse_core.sv
// ---------------------------------------------------------------------------
// pcl_parse_core
// field state of the parser; updates once per byte and forms the result
// ---------------------------------------------------------------------------
`default_nettype none

module pcl_parse_core
    import pcl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_char_info i_info,
    output t_result         o_result
);

    logic [1:0]  r_phase,  n_phase;
    logic [2:0]  r_count,  n_count;
    logic [15:0] r_first,  n_first;
    logic [15:0] r_second, n_second;
    logic [7:0]  r_third,  n_third;
    logic [3:0]  r_func,   n_func;
    logic        r_full,   n_full;
    logic        r_err,    n_err;

    logic        w_count_zero;
    logic        w_ok;
    logic [15:0] w_dom;
    logic [15:0] w_bus;
    logic [15:0] w_dev;

    assign w_count_zero = (r_count == 3'd0);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_first  = r_first;
        n_second = r_second;
        n_third  = r_third;
        n_func   = r_func;
        n_full   = r_full;
        n_err    = r_err;
        if (i_step) begin
            if (i_info.is_term) begin
                n_phase  = PH_FIRST;
                n_count  = 3'd0;
                n_first  = 16'h0000;
                n_second = 16'h0000;
                n_third  = 8'h00;
                n_func   = 4'h0;
                n_full   = 1'b0;
                n_err    = 1'b0;
            end else if (!r_err) begin
                unique case (r_phase)
                    PH_FIRST: begin
                        if (i_info.is_hex) begin
                            if (r_count >= MAX_WIDE_DIGITS) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count + 3'd1;
                                n_first = {r_first[11:0], i_info.digit};
                            end
                        end else if (i_info.is_colon && !w_count_zero) begin
                            n_phase = PH_SECOND;
                            n_count = 3'd0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_SECOND: begin
                        if (i_info.is_hex) begin
                            if (r_count >= MAX_WIDE_DIGITS) begin
                                n_err = 1'b1;
                            end else begin
                                n_count  = r_count + 3'd1;
                                n_second = {r_second[11:0], i_info.digit};
                            end
                        end else if (i_info.is_colon && !w_count_zero) begin
                            n_full  = 1'b1;
                            n_phase = PH_DEVICE;
                            n_count = 3'd0;
                        end else if (i_info.is_dot && !w_count_zero) begin
                            n_full  = 1'b0;
                            n_phase = PH_FUNC;
                            n_count = 3'd0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_DEVICE: begin
                        if (i_info.is_hex) begin
                            if (r_count >= MAX_DEV_DIGITS) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count + 3'd1;
                                n_third = {r_third[3:0], i_info.digit};
                            end
                        end else if (i_info.is_dot && !w_count_zero) begin
                            n_phase = PH_FUNC;
                            n_count = 3'd0;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_FUNC: begin
                        if (i_info.is_hex && (r_count < MAX_FUNC_DIGITS)) begin
                            n_count = r_count + 3'd1;
                            n_func  = i_info.digit;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // result as seen by a terminator arriving now
    always_comb begin
        if (r_full) begin
            w_dom = r_first;
            w_bus = r_second;
            w_dev = {8'h00, r_third};
        end else begin
            w_dom = 16'h0000;
            w_bus = r_first;
            w_dev = r_second;
        end
        w_ok = !r_err && (r_phase == PH_FUNC) && (r_count == MAX_FUNC_DIGITS)
            && (w_bus <= BUS_MAX) && (w_dev <= DEV_MAX) && (r_func <= FUNC_MAX);
        o_result.ok           = w_ok;
        o_result.domain_num   = w_ok ? w_dom : 16'h0000;
        o_result.bus_num      = w_ok ? w_bus[7:0] : 8'h00;
        o_result.device_num   = w_ok ? w_dev[4:0] : 5'h00;
        o_result.function_num = w_ok ? r_func[2:0] : 3'h0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_count  <= 3'd0;
            r_first  <= 16'h0000;
            r_second <= 16'h0000;
            r_third  <= 8'h00;
            r_func   <= 4'h0;
            r_full   <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_first  <= n_first;
            r_second <= n_second;
            r_third  <= n_third;
            r_func   <= n_func;
            r_full   <= n_full;
            r_err    <= n_err;
        end
    end

endmodule

`default_nettype wire

>>> sv/pci_location_string_parser.sv
// ---------------------------------------------------------------------------
// pci_location_string_parser
// parses a pci location string, one byte per request, into domain, bus,
// device and function; one result per string, on the zero terminator
// ---------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  input    | i_valid o_ready i_char_byte     | in
//  result   | o_valid i_ready o_ok o_*_num    | out
//
//  one byte per cycle sustained while no terminator waits on a stalled result;
//  each byte is held in the input register; a result is registered when its
//  terminator leaves the input register and the output register is free
//  synchronous active-low reset clears the parser state and both valid flags
//  a stalled result only holds back a waiting terminator; other bytes go on
// ---------------------------------------------------------------------------
`default_nettype none

`include "pci_location_string_parser_defines.svh"

module pci_location_string_parser
    import pcl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_ok,
    output logic [15:0]      o_domain_num,
    output logic [7:0]       o_bus_num,
    output logic [4:0]       o_device_num,
    output logic [2:0]       o_function_num
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    t_char_info w_info;
    t_result    w_result;
    logic       w_out_free;
    logic       w_advance;

    pcl_char_decode u_decode (
        .i_char_byte (r_in_byte),
        .o_info      (w_info)
    );

    pcl_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_info   (w_info),
        .o_result (w_result)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && (!w_info.is_term || w_out_free);
    assign o_ready    = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance && w_info.is_term) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_char_byte;
        end
        if (w_advance && w_info.is_term) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ok           = r_out.ok;
    assign o_domain_num   = r_out.domain_num;
    assign o_bus_num      = r_out.bus_num;
    assign o_device_num   = r_out.device_num;
    assign o_function_num = r_out.function_num;

    `PCL_ASSERT_SAME(a_fail_zero, o_valid && !o_ok, (o_domain_num == 16'h0000) && (o_bus_num == 8'h00) && (o_device_num == 5'h00) && (o_function_num == 3'h0), "failed result carries nonzero fields")
    `PCL_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance, r_in_valid && $stable(r_in_byte), "stalled input byte lost")
    `PCL_ASSERT_NEXT(a_no_spurious, r_in_valid && !w_info.is_term && !r_out_valid, !r_out_valid, "result without terminator")

endmodule

`default_nettype wire

>>> tb/sv/pci_location_string_parser_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pci_location_string_parser_checker
// watches both channels of the location string parser, keeps its own parse
// state for every accepted byte and compares each result, field by field,
// with the oldest predicted location
// ---------------------------------------------------------------------------
module pci_location_string_parser_checker
    import pcl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [7:0]  i_req_char,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic        i_rsp_ok,
    input  wire logic [15:0] i_rsp_domain,
    input  wire logic [7:0]  i_rsp_bus,
    input  wire logic [4:0]  i_rsp_device,
    input  wire logic [2:0]  i_rsp_function,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [4:0] NOT_HEX    = 5'd16;
    localparam int         REPORT_MAX = 10;

    logic [1:0]  field_phase  = PH_FIRST;
    logic [2:0]  digit_count  = 3'd0;
    logic [15:0] first_field  = 16'd0;
    logic [15:0] second_field = 16'd0;
    logic [7:0]  device_field = 8'd0;
    logic [3:0]  func_field   = 4'd0;
    logic        full_form    = 1'b0;
    logic        parse_error  = 1'b0;

    t_result expected_locations[$];
    int      mismatch_count = 0;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 5'(c - CH_DIGIT_0);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A + 8'd10);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 5'(c - CH_LOWER_A + 8'd10);
        return NOT_HEX;
    endfunction

    task automatic clear_parse();
        field_phase  = PH_FIRST;
        digit_count  = 3'd0;
        first_field  = 16'd0;
        second_field = 16'd0;
        device_field = 8'd0;
        func_field   = 4'd0;
        full_form    = 1'b0;
        parse_error  = 1'b0;
    endtask

    // claims one digit slot in the current field, or flags an overlong field
    task automatic claim_digit(input logic [2:0] max_digits, output logic room);
        if (digit_count >= max_digits) begin
            parse_error = 1'b1;
            room        = 1'b0;
        end else begin
            digit_count = digit_count + 3'd1;
            room        = 1'b1;
        end
    endtask

    task automatic close_field(input logic [1:0] next_phase);
        if (digit_count == 3'd0) begin
            parse_error = 1'b1;
        end else begin
            field_phase = next_phase;
            digit_count = 3'd0;
        end
    endtask

    task automatic finish_location();
        t_result     loc;
        logic        ok;
        logic [15:0] dom;
        logic [15:0] bus;
        logic [15:0] dev;
        logic [3:0]  fn;
        loc = '0;
        ok  = !parse_error && field_phase == PH_FUNC && digit_count == 3'd1;
        if (full_form) begin
            dom = first_field;
            bus = second_field;
            dev = {8'd0, device_field};
        end else begin
            dom = 16'd0;
            bus = first_field;
            dev = second_field;
        end
        fn = func_field;
        if (bus > BUS_MAX || dev > DEV_MAX || fn > FUNC_MAX) ok = 1'b0;
        if (ok) begin
            loc.ok           = 1'b1;
            loc.domain_num   = dom;
            loc.bus_num      = bus[7:0];
            loc.device_num   = dev[4:0];
            loc.function_num = fn[2:0];
        end
        expected_locations.push_back(loc);
        clear_parse();
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [4:0] d;
        logic       room;
        d = hex_value(c);
        if (c == CHAR_TERM) begin
            finish_location();
        end else if (!parse_error) begin
            case (field_phase)
                PH_FIRST: begin
                    if (d != NOT_HEX) begin
                        claim_digit(MAX_WIDE_DIGITS, room);
                        if (room) first_field = {first_field[11:0], d[3:0]};
                    end else if (c == CHAR_COLON) begin
                        close_field(PH_SECOND);
                    end else begin
                        parse_error = 1'b1;
                    end
                end
                PH_SECOND: begin
                    if (d != NOT_HEX) begin
                        claim_digit(MAX_WIDE_DIGITS, room);
                        if (room) second_field = {second_field[11:0], d[3:0]};
                    end else if (c == CHAR_COLON) begin
                        if (digit_count != 3'd0) full_form = 1'b1;
                        close_field(PH_DEVICE);
                    end else if (c == CHAR_DOT) begin
                        if (digit_count != 3'd0) full_form = 1'b0;
                        close_field(PH_FUNC);
                    end else begin
                        parse_error = 1'b1;
                    end
                end
                PH_DEVICE: begin
                    if (d != NOT_HEX) begin
                        claim_digit(MAX_DEV_DIGITS, room);
                        if (room) device_field = {device_field[3:0], d[3:0]};
                    end else if (c == CHAR_DOT) begin
                        close_field(PH_FUNC);
                    end else begin
                        parse_error = 1'b1;
                    end
                end
                PH_FUNC: begin
                    if (d != NOT_HEX) begin
                        claim_digit(MAX_FUNC_DIGITS, room);
                        if (room) func_field = d[3:0];
                    end else begin
                        parse_error = 1'b1;
                    end
                end
                default: begin
                    parse_error = 1'b1;
                end
            endcase
        end
    endtask

    task automatic check_location();
        t_result want;
        t_result got;
        got = {i_rsp_ok, i_rsp_domain, i_rsp_bus, i_rsp_device, i_rsp_function};
        if (expected_locations.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
                $display("unexpected result: ok=%0b domain=%h bus=%h device=%h function=%h",
                         got.ok, got.domain_num, got.bus_num, got.device_num,
                         got.function_num);
            mismatch_count++;
        end else begin
            want = expected_locations.pop_front();
            if (got.ok !== want.ok || got.domain_num !== want.domain_num ||
                got.bus_num !== want.bus_num || got.device_num !== want.device_num ||
                got.function_num !== want.function_num) begin
                if (mismatch_count < REPORT_MAX)
                    $display("mismatch: expected ok=%0b %h:%h:%h.%h, got ok=%0b %h:%h:%h.%h",
                             want.ok, want.domain_num, want.bus_num, want.device_num,
                             want.function_num, got.ok, got.domain_num, got.bus_num,
                             got.device_num, got.function_num);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) check_location();
            if (i_req_valid && i_req_ready) parse_char(i_req_char);
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_locations.size();
    end

endmodule

>>> tb/sv/pci_location_string_parser_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pci_location_string_parser_tb
// drives location strings into the parser, a few hand-picked ones and then
// random well-formed, broken and noise strings, with random idle bursts on
// both channels and one long result stall; the checker predicts every result
// ---------------------------------------------------------------------------
module pci_location_string_parser_tb;
    import pcl_pkg::*;

    localparam int STREAM_TARGET = 1050;
    localparam int HOLD_START    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_TAIL    = 150;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_byte = 8'd0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_ok;
    logic [15:0] o_domain_num;
    logic [7:0]  o_bus_num;
    logic [4:0]  o_device_num;
    logic [2:0]  o_function_num;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    logic        hold_done   = 1'b0;
    logic [7:0]  char_stream[$];

    pci_location_string_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_byte    (i_char_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_ok           (o_ok),
        .o_domain_num   (o_domain_num),
        .o_bus_num      (o_bus_num),
        .o_device_num   (o_device_num),
        .o_function_num (o_function_num)
    );

    pci_location_string_parser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req_char     (i_char_byte),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_rsp_ok       (o_ok),
        .i_rsp_domain   (o_domain_num),
        .i_rsp_bus      (o_bus_num),
        .i_rsp_device   (o_device_num),
        .i_rsp_function (o_function_num),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pci_location_string_parser_tb failed");
            $finish;
        end
    end

    task automatic push_line(input string s);
        for (int k = 0; k < s.len(); k++) char_stream.push_back(s[k]);
        char_stream.push_back(CHAR_TERM);
    endtask

    // hex digits of the low nibbles, case picked per digit
    task automatic append_hex(input logic [15:0] value, input int digits);
        string lower_digits;
        string upper_digits;
        int    nib;
        lower_digits = "0123456789abcdef";
        upper_digits = "0123456789ABCDEF";
        for (int k = digits - 1; k >= 0; k--) begin
            nib = value[4*k +: 4];
            if ($urandom_range(0, 1) == 0) char_stream.push_back(lower_digits[nib]);
            else char_stream.push_back(upper_digits[nib]);
        end
    endtask

    function automatic logic [15:0] pick_value(input int small_max);
        if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, small_max));
        return 16'($urandom);
    endfunction

    task automatic push_random_location();
        int kind;
        int start;
        int pos;
        int len;
        kind  = $urandom_range(0, 99);
        start = char_stream.size();
        if (kind < 85) begin
            if (kind < 45) begin
                append_hex(16'($urandom), $urandom_range(1, 4));
                char_stream.push_back(CHAR_COLON);
                append_hex(pick_value(255), $urandom_range(1, 4));
                char_stream.push_back(CHAR_COLON);
                append_hex(pick_value(31), $urandom_range(1, 2));
            end else begin
                append_hex(pick_value(255), $urandom_range(1, 4));
                char_stream.push_back(CHAR_COLON);
                append_hex(pick_value(31), $urandom_range(1, 4));
            end
            char_stream.push_back(CHAR_DOT);
            append_hex(($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7))
                                                   : 16'($urandom_range(0, 15)), 1);
            // broken strings: one byte replaced, dropped, added, or an early end
            if (kind >= 70) begin
                pos = $urandom_range(start, char_stream.size() - 1);
                case ($urandom_range(0, 3))
                    0: char_stream[pos] = 8'($urandom_range(1, 255));
                    1: char_stream.delete(pos);
                    2: char_stream.insert(pos, ($urandom_range(0, 1) == 0) ? CHAR_COLON
                                                                           : CHAR_DOT);
                    default: begin
                        while (char_stream.size() > pos) char_stream.delete(pos);
                    end
                endcase
            end
        end else begin
            len = $urandom_range(0, 8);
            for (int k = 0; k < len; k++) char_stream.push_back(8'($urandom_range(1, 255)));
        end
        char_stream.push_back(CHAR_TERM);
    endtask

    task automatic build_stream();
        push_line("FFFF:ff:1F.7");
        push_line("0:0.0");
        push_line("100:0.0");
        push_line("1:20.8");
        push_line("");
        push_line("1:2");
        push_line("12345:0");
        push_line("1.2:3");
        while (char_stream.size() < STREAM_TARGET) push_random_location();
    endtask

    initial begin
        build_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (bytes_sent < char_stream.size()) begin
            if (bytes_sent + QUIET_TAIL < char_stream.size() && (bytes_sent % 64) < 48 &&
                $urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_char_byte <= char_stream[bytes_sent];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            bytes_sent++;
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("pci_location_string_parser_tb passed");
        end else begin
            $display("pci_location_string_parser_tb failed");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, always ready near the end
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (bytes_sent + QUIET_TAIL >= char_stream.size()) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else if (!hold_done && bytes_sent >= HOLD_START) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

endmodule

>>> filelist.f
+incdir+sv
sv/pcl_pkg.sv
sv/pcl_char_decode.sv
sv/pcl_parse_core.sv
sv/pci_location_string_parser.sv
tb/sv/pci_location_string_parser_checker.sv
tb/sv/pci_location_string_parser_tb.sv
